FILE: sv/t16se_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// t16se_pkg
// Shared types, decode constants and helper functions of the Thumb subset
// executor.
// ----------------------------------------------------------------------------
package t16se_pkg;

	localparam int unsigned MEM_ADDR_BITS_DEF = 12;

	// Instruction group decode
	localparam logic [15:0] GRP_MASK   = 16'hE000;
	localparam logic [15:0] GRP_IMM    = 16'h2000;
	localparam logic [15:0] GRP_LS     = 16'h6000;
	localparam logic [15:0] BR_MASK    = 16'hF800;
	localparam logic [15:0] BR_CODE    = 16'hE000;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_ALU    = 2'd1,
		KIND_LS     = 2'd2,
		KIND_BRANCH = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OP_MOV = 2'd0,
		OP_CMP = 2'd1,
		OP_ADD = 2'd2,
		OP_SUB = 2'd3
	} alu_op_t;

	// Register file write port
	typedef struct packed {
		logic        en;
		logic [2:0]  addr;
		logic [31:0] data;
	} rf_wr_t;

	// Data memory request
	typedef struct packed {
		logic        rd;
		logic        wr;
		logic        is_byte;
		logic [31:0] addr;
		logic [31:0] wdata;
	} dm_req_t;

	function automatic kind_t decode_kind(input logic [15:0] ins);
		kind_t k;
		k = KIND_NONE;
		if ((ins & GRP_MASK) == GRP_IMM) begin
			k = KIND_ALU;
		end else if ((ins & GRP_MASK) == GRP_LS) begin
			k = KIND_LS;
		end else if ((ins & BR_MASK) == BR_CODE) begin
			k = KIND_BRANCH;
		end
		return k;
	endfunction

	// Destination / data register: bits 10:8 for immediate ALU, else 2:0
	function automatic logic [2:0] port_a_index(input logic [15:0] ins);
		logic [2:0] idx;
		idx = (decode_kind(ins) == KIND_ALU) ? ins[10:8] : ins[2:0];
		return idx;
	endfunction

endpackage
`default_nettype wire

FILE: sv/t16se_instr_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// t16se_instr_if
// Instruction channel: valid/ready handshake carrying one 16-bit opcode.
// ----------------------------------------------------------------------------
interface t16se_instr_if;
	logic        valid;
	logic        ready;
	logic [15:0] instruction;

	modport source (output valid, output instruction, input ready);
	modport sink   (input valid, input instruction, output ready);
endinterface
`default_nettype wire

FILE: sv/t16se_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// t16se_result_if
// Result channel: valid/ready handshake carrying one execution record.
// ----------------------------------------------------------------------------
interface t16se_result_if;
	logic        valid;
	logic        ready;
	logic [1:0]  format_kind;
	logic [31:0] next_pc;
	logic        reg_written;
	logic [2:0]  reg_index;
	logic [31:0] reg_value;
	logic        mem_written;
	logic [31:0] mem_address;
	logic        mem_is_byte;
	logic [31:0] store_value;
	logic        negative_flag;
	logic        zero_flag;

	modport source (
		output valid, output format_kind, output next_pc, output reg_written,
		output reg_index, output reg_value, output mem_written,
		output mem_address, output mem_is_byte, output store_value,
		output negative_flag, output zero_flag, input ready
	);
	modport sink (
		input valid, input format_kind, input next_pc, input reg_written,
		input reg_index, input reg_value, input mem_written,
		input mem_address, input mem_is_byte, input store_value,
		input negative_flag, input zero_flag, output ready
	);
endinterface
`default_nettype wire

FILE: sv/t16se_regfile.sv
`default_nettype none
// ----------------------------------------------------------------------------
// t16se_regfile
// Eight 32-bit low registers, two registered read ports, one write port.
// Write-first on a same-edge collision; unwritten entries read as zero.
// ----------------------------------------------------------------------------
module t16se_regfile (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 rd_en,
	input  wire  [2:0]          rd_addr_a,
	input  wire  [2:0]          rd_addr_b,
	output logic [31:0]         rd_data_a,
	output logic [31:0]         rd_data_b,
	input  t16se_pkg::rf_wr_t   wr
);

	logic [31:0] regs_q [8];
	logic [7:0]  written_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			written_q <= '0;
		end else if (wr.en) begin
			written_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en) begin
			regs_q[wr.addr] <= wr.data;
		end
	end

	// Read with write-through of a concurrent write
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr.en && wr.addr == rd_addr_a) begin
				rd_data_a <= wr.data;
			end else begin
				rd_data_a <= written_q[rd_addr_a] ? regs_q[rd_addr_a] : 32'd0;
			end
			if (wr.en && wr.addr == rd_addr_b) begin
				rd_data_b <= wr.data;
			end else begin
				rd_data_b <= written_q[rd_addr_b] ? regs_q[rd_addr_b] : 32'd0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/t16se_dmem.sv
`default_nettype none
// ----------------------------------------------------------------------------
// t16se_dmem
// Byte-addressed data memory split into four byte lanes so that any word,
// aligned or not and wrapping at the top, is read or written in one access.
// Sweeps all rows to zero after reset.
// ----------------------------------------------------------------------------
module t16se_dmem #(
	parameter int unsigned AddrBits = t16se_pkg::MEM_ADDR_BITS_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  t16se_pkg::dm_req_t  req,
	output logic [31:0]         rdata,
	output logic                busy
);

	localparam int unsigned RowBits = AddrBits - 2;
	localparam int unsigned Rows    = 1 << RowBits;

	logic [RowBits-1:0] clr_row_q;
	logic               clr_busy_q;
	logic [1:0]         off_q;
	logic [7:0]         lane_q [4];
	logic [AddrBits-1:0] base;

	assign base = req.addr[AddrBits-1:0];
	assign busy = clr_busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_row_q  <= '0;
		end else if (clr_busy_q) begin
			clr_row_q <= clr_row_q + 1'b1;
			if (clr_row_q == RowBits'(Rows - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.rd) begin
			off_q <= base[1:0];
		end
	end

	for (genvar L = 0; L < 4; L++) begin : g_lane
		localparam logic [1:0] LaneId = 2'(L);

		logic [7:0]          bank_q [Rows];
		logic [1:0]          byte_sel;
		logic [AddrBits-1:0] lane_addr;
		logic [RowBits-1:0]  row;
		logic                we;
		logic [RowBits-1:0]  wrow;
		logic [7:0]          wd;

		// Byte of the word that falls on this lane, and its row
		assign byte_sel  = LaneId - base[1:0];
		assign lane_addr = base + AddrBits'(byte_sel);
		assign row       = lane_addr[AddrBits-1:2];

		always_comb begin
			we   = clr_busy_q || (req.wr && (!req.is_byte || byte_sel == 2'd0));
			wrow = clr_busy_q ? clr_row_q : row;
			wd   = clr_busy_q ? 8'd0 : req.wdata[8*byte_sel +: 8];
		end

		always_ff @(posedge clk) begin
			if (we) begin
				bank_q[wrow] <= wd;
			end
			if (req.rd) begin
				lane_q[L] <= bank_q[row];
			end
		end
	end

	// Rotate lanes back into byte order of the access
	always_comb begin
		rdata = '0;
		for (int i = 0; i < 4; i++) begin
			rdata[8*i +: 8] = lane_q[2'(off_q + 2'(i))];
		end
	end

endmodule
`default_nettype wire

FILE: sv/thumb16_subset_executor_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// thumb16_subset_executor_unit
// Executes a subset of 16-bit Thumb opcodes against r0-r7, PC, N/Z and a
// flat byte data memory, returning one execution record per instruction.
// ----------------------------------------------------------------------------
// Use:
//   instr  : sink channel, one opcode per transaction (valid/ready).
//   result : source channel, one record per accepted opcode, in order.
// Pipeline: the accept edge reads the register file; stage 1 runs the ALU,
// address adder and branch target and issues the data memory access;
// stage 2 rotates load data, writes the register back and loads the output
// register. A record is offered from the output register once it leaves stage 2.
// Throughput is one opcode per cycle, back to back, unless result is held; a
// register written in stage 2 is forwarded into stage 1, and the register file
// writes through to a read on the same edge, so dependent opcodes never wait.
// The data memory is four byte lanes, so a word (unaligned or wrapping)
// takes one access on one port per lane.
// Reset: registers, PC and flags clear at once; the memory is cleared by a
// sweep over all 2^(MEM_ADDR_BITS-2) rows (1024 by default), during which
// instr is not ready.
// Stall: while result is held, the whole pipeline holds and instr.ready
// drops; an output register parts the two channels, so a new opcode is
// taken in the same cycle that a waiting record is taken.
// ----------------------------------------------------------------------------
module thumb16_subset_executor_unit #(
	parameter int unsigned MEM_ADDR_BITS = t16se_pkg::MEM_ADDR_BITS_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	t16se_instr_if.sink     instr,
	t16se_result_if.source  result
);

	// Pipeline control
	logic adv;
	logic accept;
	logic mem_busy;

	// Architectural state outside the memories
	logic [31:0] pc_q;
	logic        flag_n_q;
	logic        flag_z_q;

	// Stage 1
	logic        valid_s1;
	logic [15:0] instr_s1;

	// Stage 2
	logic        valid_s2;
	logic [1:0]  kind_s2;
	logic [31:0] pc_s2;
	logic        wr_s2;
	logic [2:0]  ridx_s2;
	logic [31:0] alu_s2;
	logic        load_s2;
	logic        byte_s2;
	logic        mw_s2;
	logic [31:0] maddr_s2;
	logic [31:0] sval_s2;
	logic        n_s2;
	logic        z_s2;

	// Output register
	logic        res_valid_q;

	// Memory ports
	logic [31:0]          rf_a;
	logic [31:0]          rf_b;
	t16se_pkg::rf_wr_t    rf_wr;
	t16se_pkg::dm_req_t   dm_req;
	logic [31:0]          dm_rdata;

	// Stage 1 combinational results
	t16se_pkg::kind_t  kind1;
	t16se_pkg::alu_op_t op1;
	logic [2:0]  idx_a1;
	logic [2:0]  idx_b1;
	logic [31:0] a_val;
	logic [31:0] b_val;
	logic [31:0] imm32;
	logic [31:0] sum1;
	logic [31:0] diff1;
	logic [31:0] offs1;
	logic [31:0] addr1;
	logic [31:0] br_off;
	logic [31:0] pc_next1;
	logic        wr1;
	logic [2:0]  ridx1;
	logic [31:0] alu1;
	logic        load1;
	logic        store1;
	logic        byte1;
	logic [31:0] maddr1;
	logic [31:0] sval1;
	logic        n1;
	logic        z1;
	logic [31:0] wb_val;

	// Advance everything when the output register is free or being drained
	assign adv         = !res_valid_q || result.ready;
	assign instr.ready = adv && !mem_busy;
	assign accept      = instr.valid && instr.ready;

	t16se_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (t16se_pkg::port_a_index(instr.instruction)),
		.rd_addr_b (instr.instruction[5:3]),
		.rd_data_a (rf_a),
		.rd_data_b (rf_b),
		.wr        (rf_wr)
	);

	t16se_dmem #(
		.AddrBits (MEM_ADDR_BITS)
	) u_dmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dm_req),
		.rdata  (dm_rdata),
		.busy   (mem_busy)
	);

	// Stage 2 write-back value: rotated load data or ALU result
	always_comb begin
		if (load_s2) begin
			wb_val = byte_s2 ? {24'd0, dm_rdata[7:0]} : dm_rdata;
		end else begin
			wb_val = alu_s2;
		end
	end

	always_comb begin
		rf_wr.en   = adv && valid_s2 && wr_s2;
		rf_wr.addr = ridx_s2;
		rf_wr.data = wb_val;
	end

	// Stage 1: decode, forward the register in stage 2, execute
	always_comb begin
		kind1  = t16se_pkg::decode_kind(instr_s1);
		op1    = t16se_pkg::alu_op_t'(instr_s1[12:11]);
		idx_a1 = t16se_pkg::port_a_index(instr_s1);
		idx_b1 = instr_s1[5:3];
		a_val  = (valid_s2 && wr_s2 && ridx_s2 == idx_a1) ? wb_val : rf_a;
		b_val  = (valid_s2 && wr_s2 && ridx_s2 == idx_b1) ? wb_val : rf_b;

		imm32  = {24'd0, instr_s1[7:0]};
		sum1   = a_val + imm32;
		diff1  = a_val - imm32;
		byte1  = instr_s1[12];
		offs1  = byte1 ? {27'd0, instr_s1[10:6]} : {25'd0, instr_s1[10:6], 2'b00};
		addr1  = b_val + offs1;
		br_off = {{20{instr_s1[10]}}, instr_s1[10:0], 1'b0};

		pc_next1 = pc_q + 32'd2;
		wr1      = 1'b0;
		ridx1    = 3'd0;
		alu1     = 32'd0;
		load1    = 1'b0;
		store1   = 1'b0;
		maddr1   = 32'd0;
		sval1    = 32'd0;
		n1       = flag_n_q;
		z1       = flag_z_q;

		unique case (kind1)
			t16se_pkg::KIND_ALU: begin
				unique case (op1)
					t16se_pkg::OP_MOV: begin
						wr1   = 1'b1;
						ridx1 = idx_a1;
						alu1  = imm32;
					end
					t16se_pkg::OP_CMP: begin
						n1 = diff1[31];
						z1 = (diff1 == 32'd0);
					end
					t16se_pkg::OP_ADD: begin
						wr1   = 1'b1;
						ridx1 = idx_a1;
						alu1  = sum1;
					end
					t16se_pkg::OP_SUB: begin
						wr1   = 1'b1;
						ridx1 = idx_a1;
						alu1  = diff1;
					end
					default: begin
						wr1 = 1'b0;
					end
				endcase
			end
			t16se_pkg::KIND_LS: begin
				maddr1 = addr1;
				if (instr_s1[11]) begin
					load1 = 1'b1;
					wr1   = 1'b1;
					ridx1 = idx_a1;
				end else begin
					store1 = 1'b1;
					sval1  = byte1 ? {24'd0, a_val[7:0]} : a_val;
				end
			end
			t16se_pkg::KIND_BRANCH: begin
				pc_next1 = pc_q + 32'd4 + br_off;
			end
			default: begin
				pc_next1 = pc_q + 32'd2;
			end
		endcase
	end

	// Issue the memory access as the instruction leaves stage 1
	always_comb begin
		dm_req.rd      = adv && valid_s1 && load1;
		dm_req.wr      = adv && valid_s1 && store1;
		dm_req.is_byte = byte1;
		dm_req.addr    = addr1;
		dm_req.wdata   = sval1;
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			res_valid_q <= 1'b0;
			pc_q        <= 32'd0;
			flag_n_q    <= 1'b0;
			flag_z_q    <= 1'b0;
		end else if (adv) begin
			valid_s1    <= accept;
			valid_s2    <= valid_s1;
			res_valid_q <= valid_s2;
			if (valid_s1) begin
				pc_q     <= pc_next1;
				flag_n_q <= n1;
				flag_z_q <= z1;
			end
		end
	end

	// Payload: hold on stall, advance otherwise
	always_ff @(posedge clk) begin
		if (accept) begin
			instr_s1 <= instr.instruction;
		end
		if (adv) begin
			kind_s2  <= kind1;
			pc_s2    <= pc_next1;
			wr_s2    <= wr1;
			ridx_s2  <= ridx1;
			alu_s2   <= alu1;
			load_s2  <= load1;
			byte_s2  <= (kind1 == t16se_pkg::KIND_LS) && byte1;
			mw_s2    <= store1;
			maddr_s2 <= maddr1;
			sval_s2  <= sval1;
			n_s2     <= n1;
			z_s2     <= z1;

			result.format_kind   <= kind_s2;
			result.next_pc       <= pc_s2;
			result.reg_written   <= wr_s2;
			result.reg_index     <= ridx_s2;
			result.reg_value     <= wr_s2 ? wb_val : 32'd0;
			result.mem_written   <= mw_s2;
			result.mem_address   <= maddr_s2;
			result.mem_is_byte   <= byte_s2;
			result.store_value   <= sval_s2;
			result.negative_flag <= n_s2;
			result.zero_flag     <= z_s2;
		end
	end

	assign result.valid = res_valid_q;

endmodule
`default_nettype wire
